// ===== rtl/core/lapbw_pkg.sv =====
// ----------------------------------------------------------------------------
// lapbw_pkg: shared types and constants of the border-weighted laplacian
// Field widths, register codes and the control structs that travel between
// the sequencer, the channel lanes and the output merge.
// ----------------------------------------------------------------------------
package lapbw_pkg;

    localparam int PIX_W        = 8;
    localparam int RES_W        = 11;
    localparam int IO_CH        = 3;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 40;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CHAN_REG_W   = 2;
    localparam int ROW_W        = 12;
    localparam int MAX_HEIGHT   = 4096;
    localparam int NACT_W       = 3;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_CNT_W   = 3;
    localparam int FIFO_PTR_W   = 2;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [CHAN_REG_W-1:0]   CHAN_RESET   = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    // one window shift; write marks a real pixel that updates the line buffers
    typedef struct packed {
        logic valid;
        logic write;
    } step_t;

    // which 4-neighbours of the centre lie inside the image
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } nbr_t;

    typedef struct packed {
        logic res;
        logic fend;
        nbr_t nbr;
    } tag_t;

    typedef struct packed {
        logic                        fend;
        logic [IO_CH-1:0][RES_W-1:0] chan;
    } out_t;

endpackage

// ===== rtl/core/lapbw_ctrl.sv =====
// ----------------------------------------------------------------------------
// lapbw_ctrl: frame position sequencer
// Holds the configuration registers and the pixel and flush positions, and
// decides for each transaction the line buffer access and border flags.
// ----------------------------------------------------------------------------
module lapbw_ctrl #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lapbw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lapbw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_accept,
    input  lapbw_pkg::cmd_t                      in_cmd,
    output lapbw_pkg::step_t                     a_step,
    output logic [$clog2(MAX_WIDTH)-1:0]         a_addr,
    output lapbw_pkg::step_t                     b_step,
    output logic                                 b_res,
    output lapbw_pkg::tag_t                      c_tag,
    output logic [lapbw_pkg::NACT_W-1:0]         nact
);
    import lapbw_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int FW = $clog2(MAX_WIDTH + 1);

    logic [WIDTH_REG_W-1:0]  width_reg, width_next;
    logic [HEIGHT_REG_W-1:0] height_reg, height_next;
    logic [CHAN_REG_W-1:0]   chan_reg, chan_next;
    logic [AW-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic                    flush_act_reg, flush_act_next;
    logic [FW-1:0]           flush_col_reg, flush_col_next;
    step_t                   b_step_reg;
    tag_t                    b_tag_reg, c_tag_reg, a_tag;

    logic [FW-1:0]           eff_w;
    logic [HEIGHT_REG_W-1:0] eff_h;
    logic [FW-1:0]           col_inc;
    logic [HEIGHT_REG_W-1:0] row_inc;
    logic                    restart;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (width_reg < WIDTH_REG_W'(2)) begin
            eff_w = FW'(2);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            eff_w = FW'(MAX_WIDTH);
        end else begin
            eff_w = FW'(width_reg);
        end
        if (height_reg < HEIGHT_REG_W'(2)) begin
            eff_h = HEIGHT_REG_W'(2);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            eff_h = height_reg;
        end
        if (chan_reg == '0) begin
            nact = NACT_W'(1);
        end else if (32'(chan_reg) > MAX_CHANNELS) begin
            nact = NACT_W'(MAX_CHANNELS);
        end else begin
            nact = NACT_W'(chan_reg);
        end
    end

    assign col_inc = FW'(col_reg) + FW'(1);
    assign row_inc = HEIGHT_REG_W'(row_reg) + HEIGHT_REG_W'(1);

    always_comb begin
        width_next     = width_reg;
        height_next    = height_reg;
        chan_next      = chan_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        flush_act_next = flush_act_reg;
        flush_col_next = flush_col_reg;
        a_step         = '0;
        a_tag          = '0;
        a_addr         = col_reg;
        restart        = 1'b0;

        if (in_accept) begin
            case (in_cmd)
                CMD_PIXEL: begin
                    a_step.valid   = 1'b1;
                    a_step.write   = 1'b1;
                    flush_act_next = 1'b0;
                    if (col_reg == '0 && row_reg >= ROW_W'(2)) begin
                        // right-edge pixel two rows up, finished by the row wrap
                        a_tag.res       = 1'b1;
                        a_tag.nbr.up    = row_reg >= ROW_W'(3);
                        a_tag.nbr.down  = 1'b1;
                        a_tag.nbr.left  = 1'b1;
                        a_tag.nbr.right = 1'b0;
                    end else if (row_reg >= ROW_W'(1) && col_reg >= AW'(1)) begin
                        a_tag.res       = 1'b1;
                        a_tag.nbr.up    = row_reg >= ROW_W'(2);
                        a_tag.nbr.down  = 1'b1;
                        a_tag.nbr.left  = col_reg >= AW'(2);
                        a_tag.nbr.right = 1'b1;
                    end
                    if (col_inc == eff_w) begin
                        col_next = '0;
                        if (row_inc == eff_h) begin
                            row_next       = '0;
                            flush_act_next = 1'b1;
                            flush_col_next = '0;
                        end else begin
                            row_next = row_inc[ROW_W-1:0];
                        end
                    end else begin
                        col_next = col_inc[AW-1:0];
                    end
                end
                CMD_FLUSH: begin
                    if (flush_act_reg) begin
                        a_step.valid = 1'b1;
                        a_addr       = flush_col_reg[AW-1:0];
                        a_tag.res    = 1'b1;
                        if (flush_col_reg == '0) begin
                            a_tag.nbr.up    = eff_h >= HEIGHT_REG_W'(3);
                            a_tag.nbr.down  = 1'b1;
                            a_tag.nbr.left  = 1'b1;
                            a_tag.nbr.right = 1'b0;
                        end else if (flush_col_reg == eff_w) begin
                            // bottom-right corner closes the frame
                            a_tag.nbr.up    = 1'b1;
                            a_tag.nbr.down  = 1'b0;
                            a_tag.nbr.left  = 1'b1;
                            a_tag.nbr.right = 1'b0;
                            a_tag.fend      = 1'b1;
                            flush_act_next  = 1'b0;
                        end else begin
                            a_tag.nbr.up    = 1'b1;
                            a_tag.nbr.down  = 1'b0;
                            a_tag.nbr.left  = flush_col_reg >= FW'(2);
                            a_tag.nbr.right = 1'b1;
                        end
                        flush_col_next = flush_col_reg + FW'(1);
                    end
                end
                default: ;
            endcase
        end

        if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                REG_FRAME_WIDTH: begin
                    width_next = cfg_data[WIDTH_REG_W-1:0];
                    restart    = 1'b1;
                end
                REG_FRAME_HEIGHT: begin
                    height_next = cfg_data[HEIGHT_REG_W-1:0];
                    restart     = 1'b1;
                end
                REG_CHANNEL_COUNT: begin
                    chan_next = cfg_data[CHAN_REG_W-1:0];
                    restart   = 1'b1;
                end
                default: ;
            endcase
        end

        if (restart) begin
            col_next       = '0;
            row_next       = '0;
            flush_act_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            chan_reg      <= CHAN_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            flush_act_reg <= 1'b0;
            flush_col_reg <= '0;
            b_step_reg    <= '0;
            b_tag_reg     <= '0;
            c_tag_reg     <= '0;
        end else begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            chan_reg      <= chan_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            flush_act_reg <= flush_act_next;
            flush_col_reg <= flush_col_next;
            b_step_reg    <= a_step;
            b_tag_reg     <= a_tag;
            c_tag_reg     <= b_tag_reg;
        end
    end

    assign b_step = b_step_reg;
    assign b_res  = b_tag_reg.res;
    assign c_tag  = c_tag_reg;

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        FW'(col_reg) < eff_w)
        else $error("column position beyond frame width");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        HEIGHT_REG_W'(row_reg) < eff_h)
        else $error("row position beyond frame height");

    a_flush_range: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_act_reg |-> flush_col_reg <= eff_w)
        else $error("flush column ran past the last result");

endmodule

// ===== rtl/core/lapbw_lane.sv =====
// ----------------------------------------------------------------------------
// lapbw_lane: one channel of the laplacian
// Two line buffers, a three-column window and the weighted centre minus
// neighbour sum for a single 8-bit channel.
// ----------------------------------------------------------------------------
module lapbw_lane #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lapbw_pkg::step_t                     a_step,
    input  logic [$clog2(MAX_WIDTH)-1:0]         a_addr,
    input  logic [lapbw_pkg::PIX_W-1:0]          a_pix,
    input  lapbw_pkg::step_t                     b_step,
    input  lapbw_pkg::nbr_t                      nbr,
    output logic signed [lapbw_pkg::RES_W-1:0]   result
);
    import lapbw_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
    logic [PIX_W-1:0] up_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] mid_rd_reg, up_rd_reg, b_pix_reg;
    logic [AW-1:0]    b_addr_reg;
    logic [PIX_W-1:0] win_reg [3][3];

    logic [PIX_W-1:0] ctr, u_val, d_val, l_val, r_val;
    logic [2:0]       n_cnt;
    logic [RES_W-1:0] prod, sum;

    // middle line: read-first, new pixel written at the same address
    always_ff @(posedge aclk) begin
        if (a_step.valid) begin
            mid_rd_reg <= mid_mem[a_addr];
            if (a_step.write) begin
                mid_mem[a_addr] <= a_pix;
            end
        end
    end

    // upper line takes the old middle value in the next cycle, at the registered address
    always_ff @(posedge aclk) begin
        if (a_step.valid) begin
            up_rd_reg <= up_mem[a_addr];
        end
        if (b_step.valid && b_step.write) begin
            up_mem[b_addr_reg] <= mid_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_step.valid) begin
            b_addr_reg <= a_addr;
            b_pix_reg  <= a_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[c][r] <= '0;
                end
            end
        end else if (b_step.valid) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[0][r] <= win_reg[1][r];
                win_reg[1][r] <= win_reg[2][r];
            end
            win_reg[2][0] <= up_rd_reg;
            win_reg[2][1] <= mid_rd_reg;
            win_reg[2][2] <= b_pix_reg;
        end
    end

    // centre always sits in the middle column after the shift
    always_comb begin
        ctr   = win_reg[1][1];
        u_val = nbr.up    ? win_reg[1][0] : '0;
        d_val = nbr.down  ? win_reg[1][2] : '0;
        l_val = nbr.left  ? win_reg[0][1] : '0;
        r_val = nbr.right ? win_reg[2][1] : '0;
        n_cnt = 3'(nbr.up) + 3'(nbr.down) + 3'(nbr.left) + 3'(nbr.right);
        prod  = RES_W'(ctr) * RES_W'(n_cnt);
        sum   = RES_W'(u_val) + RES_W'(d_val) + RES_W'(l_val) + RES_W'(r_val);
    end

    assign result = $signed(prod - sum);

endmodule

// ===== rtl/core/lapbw_merge.sv =====
// ----------------------------------------------------------------------------
// lapbw_merge: lane merge and output queue
// Masks inactive channels, joins the lane results with the frame end flag
// and buffers them in a small queue that drives the result stream.
// ----------------------------------------------------------------------------
module lapbw_merge #(
    parameter int LANES = 3
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   b_res,
    input  lapbw_pkg::tag_t                        c_tag,
    input  logic signed [lapbw_pkg::RES_W-1:0]     lane_res [LANES],
    input  logic [lapbw_pkg::NACT_W-1:0]           nact,
    output logic                                   in_room,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [lapbw_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                   m_tlast
);
    import lapbw_pkg::*;

    logic [FIFO_CNT_W-1:0]       count_reg, count_next;
    logic [FIFO_PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    out_t                        fifo_mem [FIFO_DEPTH];
    logic [IO_CH-1:0][RES_W-1:0] chan_val;
    out_t                        head;
    logic                        push, pop;
    logic [FIFO_CNT_W-1:0]       booked;

    for (genvar k = 0; k < IO_CH; k++) begin : g_chan
        if (k < LANES) begin : g_lane
            assign chan_val[k] = (NACT_W'(k) < nact) ? lane_res[k] : '0;
        end else begin : g_none
            assign chan_val[k] = '0;
        end
    end

    // queued plus in-flight results; a new transaction needs one free slot
    assign booked   = count_reg + FIFO_CNT_W'(b_res) + FIFO_CNT_W'(c_tag.res);
    assign in_room  = booked < FIFO_CNT_W'(FIFO_DEPTH);

    assign push       = c_tag.res;
    assign pop        = m_tvalid && m_tready;
    assign count_next = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg].fend <= c_tag.fend;
            fifo_mem[wr_ptr_reg].chan <= chan_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
        end
    end

    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = OUT_TDATA_W'(head.chan);
    assign m_tlast  = head.fend;

    a_booked_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        booked <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("more results in flight than queue slots");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
        else $error("result written into a full queue");

endmodule

// ===== rtl/core/laplacian_3x3_border_weighted.sv =====
// ----------------------------------------------------------------------------
// laplacian_3x3_border_weighted: streaming 4-neighbour laplacian, top level
// One lane per channel, a shared position sequencer and an output merge.
//
//   channel  direction  handshake          payload
//   s_       in         s_tvalid/s_tready  s_tdata pixel, s_tuser cmd
//   m_       out        m_tvalid/m_tready  m_tdata results, m_tlast frame end
//   cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one transaction per cycle sustained while the output queue has room; a
// result reaches m_tvalid through registered steps (line buffer read, window
// shift, lane arithmetic into a four-entry output queue).
// s_tready comes from registered queue occupancy only, so a stalled m_ side
// lets the input run on until the queue is booked full.
// reset is synchronous and active low; line buffers are not cleared.
// ----------------------------------------------------------------------------
module laplacian_3x3_border_weighted #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lapbw_pkg::IN_TDATA_W-1:0]     s_tdata,  // chan0_in, chan1_in, chan2_in
    input  logic                                 s_tuser,  // cmd
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lapbw_pkg::OUT_TDATA_W-1:0]    m_tdata,  // chan0_out, chan1_out, chan2_out
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lapbw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lapbw_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lapbw_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int LANES = (MAX_CHANNELS < IO_CH) ? MAX_CHANNELS : IO_CH;

    logic                    in_accept;
    logic                    in_room;
    step_t                   a_step, b_step;
    logic [AW-1:0]           a_addr;
    logic                    b_res;
    tag_t                    c_tag;
    logic [NACT_W-1:0]       nact;
    logic signed [RES_W-1:0] lane_res [LANES];

    assign s_tready  = in_room;
    assign in_accept = s_tvalid && s_tready;

    lapbw_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_cmd    (cmd_t'(s_tuser)),
        .a_step    (a_step),
        .a_addr    (a_addr),
        .b_step    (b_step),
        .b_res     (b_res),
        .c_tag     (c_tag),
        .nact      (nact)
    );

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        lapbw_lane #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .a_step  (a_step),
            .a_addr  (a_addr),
            .a_pix   (s_tdata[k*PIX_W +: PIX_W]),
            .b_step  (b_step),
            .nbr     (c_tag.nbr),
            .result  (lane_res[k])
        );
    end

    lapbw_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .b_res    (b_res),
        .c_tag    (c_tag),
        .lane_res (lane_res),
        .nact     (nact),
        .in_room  (in_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== verif/laplacian_3x3_border_weighted_test.sv =====
// ----------------------------------------------------------------------------
// laplacian_3x3_border_weighted_test: self-checking bench for the laplacian
// Streams pixel and flush transactions through frames of many shapes and
// channel counts. A scoreboard keeps its own line buffers and window, works
// out every result as each input transaction is taken, and compares the
// results in order, field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module laplacian_3x3_border_weighted_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lapbw_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LINE_DEPTH  = 1024;

    class laplacian_scoreboard;
        logic [WIDTH_REG_W-1:0]  width_reg;
        logic [HEIGHT_REG_W-1:0] height_reg;
        logic [CHAN_REG_W-1:0]   chan_reg;
        logic [PIX_W-1:0] upper_row  [LINE_DEPTH][IO_CH];
        logic [PIX_W-1:0] middle_row [LINE_DEPTH][IO_CH];
        logic [PIX_W-1:0] win [3][3][IO_CH];  // [column][row][channel]
        int col_pos;
        int row_pos;
        int pending;
        int errors;
        out_t expected_results [$];

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            chan_reg   = CHAN_RESET;
            foreach (upper_row[i, k]) begin
                upper_row[i][k]  = '0;
                middle_row[i][k] = '0;
            end
            foreach (win[i, j, k]) win[i][j][k] = '0;
            col_pos = 0;
            row_pos = 0;
            pending = 0;
            errors  = 0;
        endfunction

        function int width_eff();
            if (width_reg < 2) return 2;
            if (width_reg > LINE_DEPTH) return LINE_DEPTH;
            return width_reg;
        endfunction

        function int height_eff();
            if (height_reg < 2) return 2;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        function int chans_eff();
            if (chan_reg < 1) return 1;
            if (chan_reg > IO_CH) return IO_CH;
            return chan_reg;
        endfunction

        // centre weighted by the count of in-image neighbours, minus their sum
        function int weighted_lap(int ctr, bit hu, int u, bit hd, int d,
                                  bit hl, int l, bit hr, int r);
            int n;
            int s;
            n = 0;
            s = 0;
            if (hu) begin n++; s += u; end
            if (hd) begin n++; s += d; end
            if (hl) begin n++; s += l; end
            if (hr) begin n++; s += r; end
            return ctr * n - s;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_FRAME_WIDTH:   width_reg  = value[WIDTH_REG_W-1:0];
                REG_FRAME_HEIGHT:  height_reg = value[HEIGHT_REG_W-1:0];
                REG_CHANNEL_COUNT: chan_reg   = value[CHAN_REG_W-1:0];
                default: return;
            endcase
            col_pos = 0;
            row_pos = 0;
            pending = 0;
        endfunction

        function void take_input(cmd_t cmd, logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1,
                                 logic [PIX_W-1:0] c2);
            int wd, ht, nch, r, c, idx, k, j;
            logic [PIX_W-1:0] pix [IO_CH];
            out_t res;
            bit got;
            wd  = width_eff();
            ht  = height_eff();
            nch = chans_eff();
            res = '0;
            got = 1'b0;
            pix[0] = c0;
            pix[1] = c1;
            pix[2] = c2;
            if (cmd == CMD_FLUSH) begin
                if (pending == 0 || pending > wd + 1) return;
                idx = wd + 1 - pending;
                for (k = 0; k < nch; k++) begin
                    if (idx == 0) begin
                        // right-edge pixel of the second last row
                        res.chan[k] = RES_W'(weighted_lap(win[2][1][k], ht >= 3,
                                                          win[2][0][k], 1'b1, win[2][2][k],
                                                          1'b1, win[1][1][k], 1'b0, 0));
                    end else begin
                        c = idx - 1;
                        res.chan[k] = RES_W'(weighted_lap(middle_row[c][k], 1'b1,
                            upper_row[c][k], 1'b0, 0,
                            c >= 1, (c >= 1) ? middle_row[c-1][k] : 0,
                            c + 1 < wd, (c + 1 < wd) ? middle_row[c+1][k] : 0));
                    end
                end
                pending--;
                res.fend = (pending == 0);
                got = 1'b1;
            end else begin
                r = row_pos;
                c = col_pos;
                if (c >= wd) c = 0;
                if (r >= ht) r = 0;
                pending = 0;
                if (c == 0 && r >= 2) begin
                    // last pixel of row r-2, taken before the window moves on
                    for (k = 0; k < nch; k++)
                        res.chan[k] = RES_W'(weighted_lap(win[2][1][k], r >= 3,
                                                          win[2][0][k], 1'b1, win[2][2][k],
                                                          1'b1, win[1][1][k], 1'b0, 0));
                    got = 1'b1;
                end
                for (j = 0; j < 3; j++)
                    for (k = 0; k < IO_CH; k++) begin
                        win[0][j][k] = win[1][j][k];
                        win[1][j][k] = win[2][j][k];
                    end
                for (k = 0; k < IO_CH; k++) begin
                    win[2][0][k]     = upper_row[c][k];
                    win[2][1][k]     = middle_row[c][k];
                    win[2][2][k]     = pix[k];
                    upper_row[c][k]  = middle_row[c][k];
                    middle_row[c][k] = pix[k];
                end
                if (r >= 1 && c >= 1) begin
                    for (k = 0; k < nch; k++)
                        res.chan[k] = RES_W'(weighted_lap(win[1][1][k], r >= 2,
                                                          win[1][0][k], 1'b1, win[1][2][k],
                                                          c >= 2, win[0][1][k],
                                                          1'b1, win[2][1][k]));
                    got = 1'b1;
                end
                c++;
                if (c >= wd) begin
                    c = 0;
                    r++;
                    if (r >= ht) begin
                        r = 0;
                        pending = wd + 1;
                    end
                end
                col_pos = c;
                row_pos = r;
            end
            if (got) expected_results.push_back(res);
        endfunction

        function void check_output(logic [OUT_TDATA_W-1:0] data, logic last);
            out_t want;
            int k;
            if (expected_results.size() == 0) begin
                $error("result with none expected: tdata %h tlast %b", data, last);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            for (k = 0; k < IO_CH; k++) begin
                if (data[k*RES_W +: RES_W] !== want.chan[k]) begin
                    $error("chan%0d_out: expected %0d, actual %0d", k,
                           $signed(want.chan[k]), $signed(data[k*RES_W +: RES_W]));
                    errors++;
                end
            end
            if (last !== want.fend) begin
                $error("frame_end: expected %0d, actual %0d", want.fend, last);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    s_tuser   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tlast;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    laplacian_scoreboard score;
    bit  calm         = 1'b0;
    bit  source_idles = 1'b1;
    bit  sink_idles   = 1'b1;
    int  sent_items   = 0;
    int  cycle_count  = 0;

    laplacian_3x3_border_weighted dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) score.check_output(m_tdata, m_tlast);
    end

    // result side back-pressure in bursts
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!calm && sink_idles && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 14) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [PIX_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input cmd_t cmd, input logic [PIX_W-1:0] c0,
                             input logic [PIX_W-1:0] c1, input logic [PIX_W-1:0] c2);
        if (!calm && source_idles && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {c2, c1, c0};
        do @(posedge aclk); while (!s_tready);
        score.take_input(cmd, c0, c1, c2);
        sent_items++;
    endtask

    task automatic send_frame(input int pixels, input int flushes);
        repeat (pixels) send_item(CMD_PIXEL, pick_sample(), pick_sample(), pick_sample());
        repeat (flushes) send_item(CMD_FLUSH, PIX_W'($urandom), PIX_W'($urandom),
                                   PIX_W'($urandom));
    endtask

    // let the last results out and the pipeline run dry before a register write
    task automatic drain();
        s_tvalid <= 1'b0;
        while (score.expected_results.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_one(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        score.write_reg(idx, value);
    endtask

    task automatic program_regs(input logic [2:0] mask, input logic [CFG_DATA_W-1:0] wv,
                                input logic [CFG_DATA_W-1:0] hv,
                                input logic [CFG_DATA_W-1:0] cv);
        if (mask[0]) write_one(REG_FRAME_WIDTH, wv);
        if (mask[1]) write_one(REG_FRAME_HEIGHT, hv);
        if (mask[2]) write_one(REG_CHANNEL_COUNT, cv);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int wd, ht, kind, f;
        logic [PIX_W-1:0] level;
        logic [CFG_DATA_W-1:0] wv, hv;
        score = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // 3x3 checkerboard: centre reaches both ends of the output range
        program_regs(3'b111, 3, 3, 3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
                level = ((r + c) % 2 == 0) ? 8'hff : 8'h00;
                send_item(CMD_PIXEL, level, ~level, PIX_W'($urandom));
            end
        send_frame(0, 4);
        // flush with nothing left to drain
        send_item(CMD_FLUSH, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
        drain();

        // channel count zero acts as one; pixel arriving mid-drain restarts
        program_regs(3'b111, 2, 2, 0);
        send_frame(4, 1);
        send_frame(1, 0);
        drain();

        while (sent_items < 760) begin
            case ($urandom_range(0, 7))
                0: wv = CFG_DATA_W'($urandom_range(0, 1));
                1: wv = CFG_DATA_W'($urandom_range(11, 40));
                default: wv = CFG_DATA_W'($urandom_range(2, 8));
            endcase
            hv = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 1))
                                             : CFG_DATA_W'($urandom_range(2, 5));
            program_regs(3'($urandom_range(1, 7)), wv, hv,
                         CFG_DATA_W'($urandom_range(0, 3)));
            source_idles = ($urandom_range(0, 3) != 0);
            sink_idles   = ($urandom_range(0, 3) != 0);
            for (f = 0; f < 3; f++) begin
                wd   = score.width_eff();
                ht   = score.height_eff();
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    send_frame(wd * ht, wd + 1);
                end else if (kind == 7) begin
                    // cut the frame short and end the phase
                    send_frame($urandom_range(1, wd * ht - 1), 0);
                    break;
                end else if (kind == 8) begin
                    send_frame(wd * ht, $urandom_range(0, wd));
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_item(cmd_t'($urandom_range(0, 1)), pick_sample(),
                                  pick_sample(), pick_sample());
                end
            end
            drain();
        end

        calm = 1'b1;
        // tallest frame, clamped from an all-ones height
        program_regs(3'b111, 0, 13'h1fff, 2);
        send_frame(40, 3);
        drain();

        // wide frame on all channels; height below range
        program_regs(3'b111, 48, 1, 3);
        send_frame(score.width_eff() * score.height_eff(), score.width_eff() + 1);
        drain();

        if (score.errors == 0 && score.expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lapbw_pkg.sv
rtl/core/lapbw_ctrl.sv
rtl/core/lapbw_lane.sv
rtl/core/lapbw_merge.sv
rtl/core/laplacian_3x3_border_weighted.sv
verif/laplacian_3x3_border_weighted_test.sv
